// ===== hdl/fsjs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsjs_pkg
// Shared types and constants of the FCFS / SJF job scheduler: the command and
// status groups between the controller and the datapath, and the fixed widths.
// ----------------------------------------------------------------------------
package fsjs_pkg;

    localparam int STAMP_W = 32;   // cycle counter and arrival stamp
    localparam int WAIT_W  = 48;   // saturating wait total

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch the incoming item, clear per-item results
        logic set_err;     // arrival into a full store
        logic find;        // test one slot for free, write it or advance
        logic scan_issue;  // read one slot of the ready store
        logic pick;        // take the best entry out of the store
        logic tick;        // count down, add waiting jobs, advance cycle
        logic load_out;    // move results into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_tick;
        logic full;
        logic need_pick;
        logic slot_free;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage : fsjs_pkg
`default_nettype wire

// ===== hdl/fsjs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsjs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fsjs_ram #(
    parameter int WIDTH = 58,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : fsjs_ram
`default_nettype wire

// ===== hdl/fsjs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsjs_ctrl
// Controller of the scheduler: sequences arrival slot search, ready store
// scan, job pick, tick update and result hand-off.
// ----------------------------------------------------------------------------
module fsjs_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire fsjs_pkg::t_sts  i_sts,
    output fsjs_pkg::t_cmd       o_cmd
);
    import fsjs_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_FIND   = 8'b0000_0100,
        S_SCAN   = 8'b0000_1000,
        S_DRAIN  = 8'b0001_0000,
        S_PICK   = 8'b0010_0000,
        S_TICK   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_sts.is_tick) begin
                    if (i_sts.full) begin
                        o_cmd.set_err = 1'b1;
                        n_state       = S_DONE;
                    end else begin
                        n_state = S_FIND;
                    end
                end else if (i_sts.need_pick) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_TICK;
                end
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                if (i_sts.slot_free) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last read data is compared in this cycle
                n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_TICK;
            end
            S_TICK: begin
                o_cmd.tick = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_needs_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("result loaded while output register still held");

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted item not decoded");

    a_pick_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pick |-> ($past(r_state) == S_DRAIN))
        else $error("pick without a complete scan");

endmodule : fsjs_ctrl
`default_nettype wire

// ===== hdl/fsjs_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsjs_dp
// Datapath of the scheduler: ready store (valid flops plus RAM), best-entry
// compare, burst countdown, cycle counter, wait total and output register.
// ----------------------------------------------------------------------------
module fsjs_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 10,
    parameter int BURST_BITS  = 16,
    parameter int IN_W        = 32,
    parameter int OUT_W       = 72
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_wdata,
    input  wire logic [IN_W-1:0] i_in_data,
    input  wire logic            i_in_op,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output logic [OUT_W-1:0]     o_out_data,
    input  wire fsjs_pkg::t_cmd  i_cmd,
    output fsjs_pkg::t_sts       o_sts
);
    import fsjs_pkg::*;

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = ID_BITS + BURST_BITS + STAMP_W;
    localparam int RES_W   = 1 + ID_BITS + CNT_W + 1 + WAIT_W + 1;

    // control state
    logic [QUEUE_DEPTH-1:0] r_valid;
    logic [CNT_W-1:0]       r_ready_count;
    logic [BURST_BITS-1:0]  r_remaining;
    logic [STAMP_W-1:0]     r_cycle;
    logic [WAIT_W-1:0]      r_wait_sum;
    logic                   r_sf;
    logic                   r_rd_pend;
    logic                   r_best_found;
    logic                   r_out_valid;

    // payload
    logic                   r_op;
    logic [ID_BITS-1:0]     r_id;
    logic [BURST_BITS-1:0]  r_burst;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       r_rd_idx;
    logic [IDX_W-1:0]       r_best_idx;
    logic [STAMP_W-1:0]     r_best_key;
    logic [ID_BITS-1:0]     r_best_id;
    logic [BURST_BITS-1:0]  r_best_burst;
    logic                   r_started;
    logic [ID_BITS-1:0]     r_started_id;
    logic                   r_error;
    logic [OUT_W-1:0]       r_out_data;

    logic [ENTRY_W-1:0]     ram_rdata;
    logic                   ram_we;
    logic [ID_BITS-1:0]     rd_id;
    logic [BURST_BITS-1:0]  rd_burst;
    logic [STAMP_W-1:0]     rd_stamp;
    logic [STAMP_W-1:0]     rd_key;
    logic                   rd_better;
    logic                   slot_free;
    logic [WAIT_W:0]        wait_add;
    logic [RES_W-1:0]       res_word;

    assign slot_free = !r_valid[r_idx];
    assign ram_we    = i_cmd.find && slot_free;

    fsjs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata ({r_cycle, r_burst, r_id}),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_id    = ram_rdata[ID_BITS-1:0];
    assign rd_burst = ram_rdata[ID_BITS +: BURST_BITS];
    assign rd_stamp = ram_rdata[ID_BITS + BURST_BITS +: STAMP_W];
    assign rd_key   = r_sf ? STAMP_W'(rd_burst) : rd_stamp;

    // key ties go to the lower id; strict less keeps the lowest slot on a full tie
    always_comb begin
        rd_better = 1'b0;
        if (r_rd_pend && r_valid[r_rd_idx]) begin
            if (!r_best_found) begin
                rd_better = 1'b1;
            end else if (rd_key != r_best_key) begin
                rd_better = (rd_key < r_best_key);
            end else begin
                rd_better = (rd_id < r_best_id);
            end
        end
    end

    assign wait_add = {1'b0, r_wait_sum} + (WAIT_W + 1)'(r_ready_count);

    assign o_sts.is_tick   = (r_op == OP_TICK);
    assign o_sts.full      = (r_ready_count == CNT_W'(QUEUE_DEPTH));
    assign o_sts.need_pick = (r_remaining == '0) && (r_ready_count != '0);
    assign o_sts.slot_free = slot_free;
    assign o_sts.scan_last = (r_idx == IDX_W'(QUEUE_DEPTH - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign res_word = {r_error, r_wait_sum, (r_remaining != '0), r_ready_count,
                       r_started_id, r_started};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_ready_count <= '0;
            r_remaining   <= '0;
            r_cycle       <= '0;
            r_wait_sum    <= '0;
            r_sf          <= 1'b0;
            r_rd_pend     <= 1'b0;
            r_best_found  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_sf <= i_cfg_wdata;
            end
            r_rd_pend <= i_cmd.scan_issue;
            if (i_cmd.capture) begin
                r_best_found <= 1'b0;
            end else if (rd_better) begin
                r_best_found <= 1'b1;
            end
            if (ram_we) begin
                r_valid[r_idx] <= 1'b1;
                r_ready_count  <= r_ready_count + 1'b1;
            end
            if (i_cmd.pick && r_best_found) begin
                r_valid[r_best_idx] <= 1'b0;
                r_ready_count       <= r_ready_count - 1'b1;
                r_remaining         <= r_best_burst;
            end
            if (i_cmd.tick) begin
                if (r_remaining != '0) begin
                    r_remaining <= r_remaining - 1'b1;
                end
                r_wait_sum <= wait_add[WAIT_W] ? '1 : wait_add[WAIT_W-1:0];
                r_cycle    <= r_cycle + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op         <= i_in_op;
            r_id         <= i_in_data[ID_BITS-1:0];
            r_burst      <= i_in_data[ID_BITS +: BURST_BITS];
            r_idx        <= '0;
            r_started    <= 1'b0;
            r_started_id <= '0;
            r_error      <= 1'b0;
        end else if (i_cmd.scan_issue || (i_cmd.find && !slot_free)) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.set_err) begin
            r_error <= 1'b1;
        end
        r_rd_idx <= r_idx;
        if (rd_better) begin
            r_best_idx   <= r_rd_idx;
            r_best_key   <= rd_key;
            r_best_id    <= rd_id;
            r_best_burst <= rd_burst;
        end
        if (i_cmd.pick && r_best_found) begin
            r_started    <= 1'b1;
            r_started_id <= r_best_id;
        end
        if (i_cmd.load_out) begin
            r_out_data <= OUT_W'(res_word);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_ready_count) == $countones(r_valid))
        else $error("ready count out of step with valid bits");

    a_pick_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pick && r_best_found) |=> !r_valid[$past(r_best_idx)])
        else $error("picked entry still marked valid");

    a_pick_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pick |-> r_best_found)
        else $error("scan of a non-empty store found no entry");

    a_err_on_arrival: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_err |-> (r_op == OP_ARRIVE && o_sts.full))
        else $error("drop flagged outside a full arrival");

endmodule : fsjs_dp
`default_nettype wire

// ===== hdl/fcfs_sjf_job_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcfs_sjf_job_scheduler
// Non-preemptive single-CPU job scheduler, first come first served or
// shortest job first, one result per item.
// ----------------------------------------------------------------------------
// An item with tuser = 0 places a job in the ready store (id and burst in
// tdata, stamped with the current cycle count); tuser = 1 is one scheduling
// tick. Items are taken one at a time. An arrival is written to the lowest
// free slot (the free-slot search tests one valid bit a cycle); when the
// store is full the job is dropped and the error flag is set. A tick that
// starts a job first scans the whole ready store through the one read port
// of its RAM, one entry a cycle; a tick that starts no job skips the scan.
// A finished result waits in the output register while the next item is
// already accepted. shortest_first must be written through i_cfg_we /
// i_cfg_wdata only while the block is idle; the block does not enforce it.
module fcfs_sjf_job_scheduler #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 10,
    parameter int BURST_BITS  = 16,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
    localparam int IN_W       = ((ID_BITS + BURST_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((ID_BITS + CNT_W + 51 + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // configuration: shortest_first
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_wdata,
    // input items
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,  // job_id, job_burst, zero pad
    input  wire logic             s_axis_tuser,  // op
    // result items
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata   // started, started_id,
                                                 // waiting_count, busy_res,
                                                 // wait_total, error, zero pad
);
    import fsjs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    fsjs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fsjs_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .BURST_BITS  (BURST_BITS),
        .IN_W        (IN_W),
        .OUT_W       (OUT_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_in_op     (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule : fcfs_sjf_job_scheduler
`default_nettype wire
